### rtl/bsig_pkg.sv
// bipolar sigmoid unit: shared widths, constants and exp tables
`timescale 1ns / 1ps
`default_nettype none
package bsig_pkg;

	// field widths
	localparam int X_W = 16;
	localparam int Y_W = 16;
	localparam int G_W = 16;
	localparam int ACT_W = 16;
	localparam int IG_W = 16;

	// exp table samples over 0..30 in Q5.10
	localparam int TABLE_ENTRIES = 256;
	localparam int X_LIMIT = 30720;
	localparam int SPAN_SHIFT = 11;
	localparam int SPAN_ODD = 15;
	localparam int SPAN = SPAN_ODD << SPAN_SHIFT;
	localparam int SPAN_HALF = SPAN / 2;
	localparam int Y_FRAC = 14;
	localparam int EXP_FRAC = 30;
	localparam int EXP_W = EXP_FRAC + 1;
	localparam longint unsigned EXP_ONE = 64'd1 << EXP_FRAC;

	// forward index split
	localparam int A_W = $clog2(X_LIMIT + 1);
	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int P_W = $clog2(SPAN + 1);
	localparam int S_W = $clog2(X_LIMIT * TABLE_ENTRIES + 1);
	localparam int NS_W = S_W - SPAN_SHIFT;
	localparam int QI_W = $clog2(TABLE_ENTRIES + 1);
	localparam int OD_W = $clog2(SPAN_ODD);
	localparam int RM_W = $clog2(2 * SPAN_ODD);
	localparam longint unsigned RECIP_NS = (64'd1 << NS_W) / SPAN_ODD;
	localparam int R1_W = $clog2(RECIP_NS + 1);

	// truncated series terms of exp(-30/TABLE_ENTRIES) in Q0.30,
	// all zero before the last one for tables of 16 entries or more
	localparam longint unsigned EXP_TDIV = 64'(TABLE_ENTRIES);
	localparam longint unsigned EXP_T1 = (EXP_ONE * 64'd30) / EXP_TDIV;
	localparam longint unsigned EXP_T2 = (EXP_T1 * 64'd30) / (EXP_TDIV * 64'd2);
	localparam longint unsigned EXP_T3 = (EXP_T2 * 64'd30) / (EXP_TDIV * 64'd3);
	localparam longint unsigned EXP_T4 = (EXP_T3 * 64'd30) / (EXP_TDIV * 64'd4);
	localparam longint unsigned EXP_T5 = (EXP_T4 * 64'd30) / (EXP_TDIV * 64'd5);
	localparam longint unsigned EXP_T6 = (EXP_T5 * 64'd30) / (EXP_TDIV * 64'd6);
	localparam longint unsigned EXP_T7 = (EXP_T6 * 64'd30) / (EXP_TDIV * 64'd7);
	localparam longint unsigned EXP_T8 = (EXP_T7 * 64'd30) / (EXP_TDIV * 64'd8);
	localparam longint unsigned EXP_T9 = (EXP_T8 * 64'd30) / (EXP_TDIV * 64'd9);
	localparam longint unsigned EXP_T10 = (EXP_T9 * 64'd30) / (EXP_TDIV * 64'd10);
	localparam longint unsigned EXP_T11 = (EXP_T10 * 64'd30) / (EXP_TDIV * 64'd11);
	localparam longint unsigned EXP_T12 = (EXP_T11 * 64'd30) / (EXP_TDIV * 64'd12);
	localparam longint unsigned EXP_T13 = (EXP_T12 * 64'd30) / (EXP_TDIV * 64'd13);
	localparam longint unsigned EXP_T14 = (EXP_T13 * 64'd30) / (EXP_TDIV * 64'd14);
	localparam longint unsigned EXP_T15 = (EXP_T14 * 64'd30) / (EXP_TDIV * 64'd15);
	localparam longint unsigned EXP_T16 = (EXP_T15 * 64'd30) / (EXP_TDIV * 64'd16);
	localparam longint unsigned EXP_T17 = (EXP_T16 * 64'd30) / (EXP_TDIV * 64'd17);
	localparam longint unsigned EXP_T18 = (EXP_T17 * 64'd30) / (EXP_TDIV * 64'd18);
	localparam longint unsigned EXP_EVEN = EXP_ONE + EXP_T2 + EXP_T4 + EXP_T6 + EXP_T8
		+ EXP_T10 + EXP_T12 + EXP_T14 + EXP_T16 + EXP_T18;
	localparam longint unsigned EXP_ODD = EXP_T1 + EXP_T3 + EXP_T5 + EXP_T7 + EXP_T9
		+ EXP_T11 + EXP_T13 + EXP_T15 + EXP_T17;
	// ratio between neighbor samples, clamped to 0..1
	localparam longint unsigned EXP_RATIO = (EXP_ODD > EXP_EVEN) ? 64'd0
		: ((EXP_EVEN - EXP_ODD > EXP_ONE) ? EXP_ONE : EXP_EVEN - EXP_ODD);

	typedef logic [TABLE_ENTRIES:0][EXP_W-1:0] exp_tab_t;
	typedef logic [TABLE_ENTRIES-1:0][EXP_W-1:0] exp_row_t;

	// exp(-i*30/TABLE_ENTRIES) in Q1.30, geometric from the series ratio
	function automatic exp_tab_t build_exp_tab();
		exp_tab_t tab;
		longint unsigned prev;
		int i;
		tab[0] = EXP_W'(EXP_ONE);
		prev = EXP_ONE;
		for (i = 1; i <= TABLE_ENTRIES; i++) begin
			prev = (prev * EXP_RATIO + (64'd1 << (EXP_FRAC - 1))) >> EXP_FRAC;
			tab[i] = EXP_W'(prev);
		end
		return tab;
	endfunction

	function automatic exp_row_t exp_row(input int offset);
		exp_tab_t full;
		exp_row_t row;
		int i;
		full = build_exp_tab();
		for (i = 0; i < TABLE_ENTRIES; i++)
			row[i] = full[i + offset];
		return row;
	endfunction

	function automatic longint unsigned max_exp_step();
		exp_tab_t full;
		longint unsigned best;
		int i;
		full = build_exp_tab();
		best = 0;
		for (i = 0; i < TABLE_ENTRIES; i++)
			if (64'(full[i]) - 64'(full[i+1]) > best)
				best = 64'(full[i]) - 64'(full[i+1]);
		return best;
	endfunction

	localparam exp_row_t EXP_LO = exp_row(0);
	localparam exp_row_t EXP_HI = exp_row(1);

	// interpolation correction
	localparam int D_W = $clog2(max_exp_step() + 1);
	localparam int M_W = D_W + P_W;
	localparam int N_W = M_W + 1 - SPAN_SHIFT;
	localparam longint unsigned RECIP_N = (64'd1 << N_W) / SPAN_ODD;
	localparam int R2_W = $clog2(RECIP_N + 1);

	// quotient divider
	localparam int DEN_W = EXP_W + 1;
	localparam int NUM_W = EXP_W + Y_FRAC;
	localparam int QW = Y_FRAC + 1;
	localparam int DIV_STEPS = 3;
	localparam int DIV_STAGES = QW / DIV_STEPS;

	// backward path
	localparam int YY_W = 2 * Y_W;
	localparam int PROD_W = YY_W + G_W;
	localparam int BWD_ONE = 1 << (2 * Y_FRAC);
	localparam int BWD_SHIFT = 2 * Y_FRAC + 1;
	localparam int BQ_W = PROD_W - BWD_SHIFT;
	localparam int IG_MAX = (1 << (IG_W - 1)) - 1;
	localparam int IG_MIN = -(1 << (IG_W - 1));

endpackage
`default_nettype wire

### rtl/bsig_if.sv
// bipolar sigmoid unit: operand and result channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface bsig_in_if;
	logic valid;
	logic ready;
	logic action;
	logic signed [bsig_pkg::X_W-1:0] x_value;
	logic signed [bsig_pkg::Y_W-1:0] y_value;
	logic signed [bsig_pkg::G_W-1:0] grad_value;
	modport source (output valid, action, x_value, y_value, grad_value, input ready);
	modport sink (input valid, action, x_value, y_value, grad_value, output ready);
endinterface

interface bsig_out_if;
	logic valid;
	logic ready;
	logic signed [bsig_pkg::ACT_W-1:0] activation;
	logic signed [bsig_pkg::IG_W-1:0] input_gradient;
	modport source (output valid, activation, input_gradient, input ready);
	modport sink (input valid, activation, input_gradient, output ready);
endinterface
`default_nettype wire

### rtl/bipolar_sigmoid_activation.sv
// bipolar sigmoid activation with derivative, fifteen-stage pipeline
//
//  channel   dir  handshake     payload
//  operand   in   valid/ready   action, x_value, y_value, grad_value
//  result    out  valid/ready   activation, input_gradient
//
// one item per cycle unless a stalled result has filled the pipe; an item passes fifteen register
// stages: the table/interpolation stages and the 5-stage restoring divider (3 bits each)
// arst_n clears all stage valid bits; data registers are not reset
// every stage has its own valid bit and loads when it is empty or its successor moves,
// so bubbles close up and a stalled result does not block new items until the pipe fills
`timescale 1ns / 1ps
`default_nettype none
module bipolar_sigmoid_activation (
	input  wire logic clk,
	input  wire logic arst_n,
	bsig_in_if.sink   operand,
	bsig_out_if.source result
);

	localparam int ST_PREP = 9;
	localparam int ST_OUT = ST_PREP + bsig_pkg::DIV_STAGES + 1;

	typedef struct packed {
		logic act;
		logic neg;
		logic signed [bsig_pkg::IG_W-1:0] igrad;
	} meta_t;

	typedef struct packed {
		meta_t meta;
		logic [bsig_pkg::DEN_W-1:0] rem;
		logic [bsig_pkg::DEN_W-1:0] den;
		logic [bsig_pkg::QW-1:0] nlo;
		logic [bsig_pkg::QW-1:0] quo;
	} dv_t;

	// pipeline flow control
	logic [ST_OUT:1] vld_q;
	logic [ST_OUT+1:1] adv;
	logic [ST_OUT:1] vld_in;

	always_comb begin
		adv[ST_OUT+1] = result.ready;
		for (int k = ST_OUT; k >= 1; k--)
			adv[k] = !vld_q[k] || adv[k+1];
	end

	assign vld_in = {vld_q[ST_OUT-1:1], operand.valid};
	assign operand.ready = adv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else
			vld_q <= (adv[ST_OUT:1] & vld_in) | (~adv[ST_OUT:1] & vld_q);
	end

	// stage 1: clamp, magnitude, scale to table position
	meta_t meta_s1;
	logic [bsig_pkg::NS_W-1:0] ns_s1;
	logic [bsig_pkg::SPAN_SHIFT-1:0] slo_s1;
	logic signed [bsig_pkg::Y_W-1:0] y_s1;
	logic signed [bsig_pkg::G_W-1:0] g_s1;
	logic signed [bsig_pkg::X_W-1:0] xc;
	logic [bsig_pkg::A_W-1:0] xa;
	logic [bsig_pkg::S_W-1:0] xs;

	always_comb begin
		xc = operand.x_value;
		if (operand.x_value > bsig_pkg::X_W'(bsig_pkg::X_LIMIT))
			xc = bsig_pkg::X_W'(bsig_pkg::X_LIMIT);
		else if (operand.x_value < -bsig_pkg::X_W'(bsig_pkg::X_LIMIT))
			xc = -bsig_pkg::X_W'(bsig_pkg::X_LIMIT);
		xa = xc[bsig_pkg::X_W-1] ? bsig_pkg::A_W'(-xc) : bsig_pkg::A_W'(xc);
		xs = bsig_pkg::S_W'(xa) * bsig_pkg::S_W'(bsig_pkg::TABLE_ENTRIES);
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			meta_s1.act <= operand.action;
			meta_s1.neg <= operand.x_value[bsig_pkg::X_W-1];
			meta_s1.igrad <= '0;
			ns_s1 <= xs[bsig_pkg::S_W-1:bsig_pkg::SPAN_SHIFT];
			slo_s1 <= xs[bsig_pkg::SPAN_SHIFT-1:0];
			y_s1 <= operand.y_value;
			g_s1 <= operand.grad_value;
		end
	end

	// stage 2: index estimate by reciprocal, y squared
	meta_t meta_s2;
	logic [bsig_pkg::NS_W-1:0] ns_s2;
	logic [bsig_pkg::SPAN_SHIFT-1:0] slo_s2;
	logic [bsig_pkg::QI_W-1:0] qe_s2;
	logic signed [bsig_pkg::YY_W-1:0] yy_s2;
	logic signed [bsig_pkg::G_W-1:0] g_s2;
	logic [bsig_pkg::NS_W+bsig_pkg::R1_W-1:0] qe_prod;

	assign qe_prod = (bsig_pkg::NS_W+bsig_pkg::R1_W)'(ns_s1)
		* (bsig_pkg::NS_W+bsig_pkg::R1_W)'(bsig_pkg::RECIP_NS);

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			meta_s2 <= meta_s1;
			ns_s2 <= ns_s1;
			slo_s2 <= slo_s1;
			qe_s2 <= qe_prod[bsig_pkg::NS_W +: bsig_pkg::QI_W];
			yy_s2 <= bsig_pkg::YY_W'(y_s1) * bsig_pkg::YY_W'(y_s1);
			g_s2 <= g_s1;
		end
	end

	// stage 3: index correction and fraction, backward product
	meta_t meta_s3;
	logic [bsig_pkg::IDX_W-1:0] idx_s3;
	logic [bsig_pkg::P_W-1:0] p_s3;
	logic signed [bsig_pkg::PROD_W-1:0] prod_s3;
	logic [bsig_pkg::RM_W-1:0] rem_a;
	logic fix_a;
	logic [bsig_pkg::QI_W-1:0] qidx;
	logic [bsig_pkg::OD_W-1:0] rem_odd;
	logic [bsig_pkg::IDX_W-1:0] idx_nx;
	logic [bsig_pkg::P_W-1:0] p_nx;
	logic signed [bsig_pkg::YY_W-1:0] dd;

	always_comb begin
		// remainder is below twice the odd factor, so the low bits suffice
		rem_a = ns_s2[bsig_pkg::RM_W-1:0]
			- bsig_pkg::RM_W'(qe_s2[bsig_pkg::RM_W-1:0] * bsig_pkg::RM_W'(bsig_pkg::SPAN_ODD));
		fix_a = rem_a >= bsig_pkg::RM_W'(bsig_pkg::SPAN_ODD);
		qidx = qe_s2 + bsig_pkg::QI_W'(fix_a);
		rem_odd = fix_a ? bsig_pkg::OD_W'(rem_a - bsig_pkg::RM_W'(bsig_pkg::SPAN_ODD))
			: bsig_pkg::OD_W'(rem_a);
		idx_nx = bsig_pkg::IDX_W'(qidx);
		p_nx = bsig_pkg::P_W'({rem_odd, slo_s2});
		// last sample: step back one entry with a full span of interpolation
		if (qidx >= bsig_pkg::QI_W'(bsig_pkg::TABLE_ENTRIES)) begin
			idx_nx = bsig_pkg::IDX_W'(bsig_pkg::TABLE_ENTRIES - 1);
			p_nx = bsig_pkg::P_W'(bsig_pkg::SPAN);
		end
		dd = bsig_pkg::YY_W'(bsig_pkg::BWD_ONE) - yy_s2;
	end

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			meta_s3 <= meta_s2;
			idx_s3 <= idx_nx;
			p_s3 <= p_nx;
			prod_s3 <= bsig_pkg::PROD_W'(dd) * bsig_pkg::PROD_W'(g_s2);
		end
	end

	// stage 4: table read, backward rounding and saturation
	meta_t meta_s4;
	logic [bsig_pkg::EXP_W-1:0] lo_s4;
	logic [bsig_pkg::D_W-1:0] d_s4;
	logic [bsig_pkg::P_W-1:0] p_s4;
	logic [bsig_pkg::EXP_W-1:0] tab_lo;
	logic [bsig_pkg::EXP_W-1:0] tab_hi;
	logic signed [bsig_pkg::PROD_W-1:0] biased;
	logic signed [bsig_pkg::BQ_W-1:0] bq;
	logic signed [bsig_pkg::IG_W-1:0] bsat;

	always_comb begin
		tab_lo = bsig_pkg::EXP_LO[idx_s3];
		tab_hi = bsig_pkg::EXP_HI[idx_s3];
		biased = prod_s3 + bsig_pkg::PROD_W'(bsig_pkg::BWD_ONE);
		bq = bsig_pkg::BQ_W'(biased >>> bsig_pkg::BWD_SHIFT);
		if (bq > bsig_pkg::BQ_W'(bsig_pkg::IG_MAX))
			bsat = bsig_pkg::IG_W'(bsig_pkg::IG_MAX);
		else if (bq < bsig_pkg::BQ_W'(bsig_pkg::IG_MIN))
			bsat = bsig_pkg::IG_W'(bsig_pkg::IG_MIN);
		else
			bsat = bsig_pkg::IG_W'(bq);
	end

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			meta_s4.act <= meta_s3.act;
			meta_s4.neg <= meta_s3.neg;
			meta_s4.igrad <= meta_s3.act ? bsat : '0;
			lo_s4 <= tab_lo;
			d_s4 <= bsig_pkg::D_W'(tab_lo - tab_hi);
			p_s4 <= p_s3;
		end
	end

	// stage 5: step times fraction
	meta_t meta_s5;
	logic [bsig_pkg::EXP_W-1:0] lo_s5;
	logic [bsig_pkg::M_W-1:0] m_s5;

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			meta_s5 <= meta_s4;
			lo_s5 <= lo_s4;
			m_s5 <= bsig_pkg::M_W'(d_s4) * bsig_pkg::M_W'(p_s4);
		end
	end

	// stage 6: round and drop the power-of-two part of the span
	meta_t meta_s6;
	logic [bsig_pkg::EXP_W-1:0] lo_s6;
	logic [bsig_pkg::N_W-1:0] n_s6;
	logic [bsig_pkg::M_W:0] m_rnd;

	assign m_rnd = (bsig_pkg::M_W+1)'(m_s5) + (bsig_pkg::M_W+1)'(bsig_pkg::SPAN_HALF);

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			meta_s6 <= meta_s5;
			lo_s6 <= lo_s5;
			n_s6 <= bsig_pkg::N_W'(m_rnd >> bsig_pkg::SPAN_SHIFT);
		end
	end

	// stage 7: divide by the odd factor, reciprocal estimate
	meta_t meta_s7;
	logic [bsig_pkg::EXP_W-1:0] lo_s7;
	logic [bsig_pkg::RM_W-1:0] nlo_s7;
	logic [bsig_pkg::D_W-1:0] qa_s7;
	logic [bsig_pkg::N_W+bsig_pkg::R2_W-1:0] qa_prod;

	assign qa_prod = (bsig_pkg::N_W+bsig_pkg::R2_W)'(n_s6)
		* (bsig_pkg::N_W+bsig_pkg::R2_W)'(bsig_pkg::RECIP_N);

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			meta_s7 <= meta_s6;
			lo_s7 <= lo_s6;
			nlo_s7 <= n_s6[bsig_pkg::RM_W-1:0];
			qa_s7 <= qa_prod[bsig_pkg::N_W +: bsig_pkg::D_W];
		end
	end

	// stage 8: estimate correction, interpolated exp
	meta_t meta_s8;
	logic [bsig_pkg::EXP_W-1:0] e_s8;
	logic [bsig_pkg::RM_W-1:0] rem_b;
	logic fix_b;

	always_comb begin
		rem_b = nlo_s7
			- bsig_pkg::RM_W'(qa_s7[bsig_pkg::RM_W-1:0] * bsig_pkg::RM_W'(bsig_pkg::SPAN_ODD));
		fix_b = rem_b >= bsig_pkg::RM_W'(bsig_pkg::SPAN_ODD);
	end

	always_ff @(posedge clk) begin
		if (adv[8]) begin
			meta_s8 <= meta_s7;
			e_s8 <= lo_s7 - bsig_pkg::EXP_W'(qa_s7) - bsig_pkg::EXP_W'(fix_b);
		end
	end

	// stage 9: numerator and denominator of (1-e)/(1+e)
	dv_t dv_s9;
	logic [bsig_pkg::EXP_W-1:0] ome;
	logic [bsig_pkg::DEN_W-1:0] den_nx;
	logic [bsig_pkg::NUM_W-1:0] num_nx;

	always_comb begin
		ome = bsig_pkg::EXP_W'(bsig_pkg::EXP_ONE) - e_s8;
		den_nx = bsig_pkg::DEN_W'(bsig_pkg::EXP_ONE) + bsig_pkg::DEN_W'(e_s8);
		num_nx = (bsig_pkg::NUM_W'(ome) << bsig_pkg::Y_FRAC)
			+ bsig_pkg::NUM_W'(den_nx >> 1);
	end

	always_ff @(posedge clk) begin
		if (adv[ST_PREP]) begin
			dv_s9.meta <= meta_s8;
			dv_s9.rem <= bsig_pkg::DEN_W'(num_nx >> bsig_pkg::QW);
			dv_s9.den <= den_nx;
			dv_s9.nlo <= num_nx[bsig_pkg::QW-1:0];
			dv_s9.quo <= '0;
		end
	end

	// stages 10..14: restoring divider, three quotient bits per stage
	dv_t dv_s [bsig_pkg::DIV_STAGES];

	for (genvar j = 0; j < bsig_pkg::DIV_STAGES; j++) begin : g_div
		dv_t prev;
		dv_t nxt;

		if (j == 0) begin : g_first
			assign prev = dv_s9;
		end else begin : g_next
			assign prev = dv_s[j-1];
		end

		always_comb begin
			logic [bsig_pkg::DEN_W:0] trial;
			nxt = prev;
			for (int st = 0; st < bsig_pkg::DIV_STEPS; st++) begin
				trial = {nxt.rem, nxt.nlo[bsig_pkg::QW-1]};
				if (trial >= {1'b0, nxt.den}) begin
					nxt.rem = bsig_pkg::DEN_W'(trial - {1'b0, nxt.den});
					nxt.quo = {nxt.quo[bsig_pkg::QW-2:0], 1'b1};
				end else begin
					nxt.rem = trial[bsig_pkg::DEN_W-1:0];
					nxt.quo = {nxt.quo[bsig_pkg::QW-2:0], 1'b0};
				end
				nxt.nlo = {nxt.nlo[bsig_pkg::QW-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk) begin
			if (adv[ST_PREP+1+j])
				dv_s[j] <= nxt;
		end
	end

	// stage 15: sign and action select, output register
	logic act_s15;
	logic signed [bsig_pkg::ACT_W-1:0] activation_s15;
	logic signed [bsig_pkg::IG_W-1:0] igrad_s15;
	dv_t dv_last;
	logic signed [bsig_pkg::ACT_W-1:0] tmag;

	assign dv_last = dv_s[bsig_pkg::DIV_STAGES-1];
	assign tmag = bsig_pkg::ACT_W'(dv_last.quo);

	always_ff @(posedge clk) begin
		if (adv[ST_OUT]) begin
			act_s15 <= dv_last.meta.act;
			igrad_s15 <= dv_last.meta.igrad;
			if (dv_last.meta.act)
				activation_s15 <= '0;
			else if (dv_last.meta.neg)
				activation_s15 <= -tmag;
			else
				activation_s15 <= tmag;
		end
	end

	assign result.valid = vld_q[ST_OUT];
	assign result.activation = activation_s15;
	assign result.input_gradient = igrad_s15;

	// checks
	a_bwd_zero_act: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && act_s15 |-> result.activation == '0)
		else $error("backward item carries a nonzero activation");

	a_act_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !act_s15 |->
			(result.activation <= bsig_pkg::ACT_W'(16384)
			&& result.activation >= -bsig_pkg::ACT_W'(16384)))
		else $error("activation outside plus or minus one");

	a_ready_flow: assert property (@(posedge clk) disable iff (!arst_n)
		result.ready |-> operand.ready)
		else $error("pipeline refuses an item while the result side drains");

	a_quo_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[ST_OUT-1] |-> dv_last.quo <= bsig_pkg::QW'(16384))
		else $error("divider quotient exceeds one");

endmodule
`default_nettype wire
